### sv/bpfa_pkg.sv
// Package for the bitmap page-frame allocator: constants, codes and shared types.
package bpfa_pkg;

	localparam int NUM_PAGES_DEF = 4096;
	localparam int WORD_BITS     = 64;
	localparam int WORD_IDX_W    = $clog2(WORD_BITS);
	localparam int CHUNK_BITS    = 8;
	localparam int CHUNK_POS_W   = $clog2(CHUNK_BITS);
	localparam int CHUNKS        = WORD_BITS / CHUNK_BITS;
	localparam int CHUNK_IDX_W   = $clog2(CHUNKS);
	localparam int LEN_W         = 13;
	localparam int PAGE_W        = 12;
	localparam int STATUS_W      = 2;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ZERO    = 2'd2;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_SCAN_RD,
		S_SCAN,
		S_UPD_RD,
		S_UPD_WR,
		S_RESP
	} state_t;

	typedef struct packed {
		logic                   hit;
		logic [CHUNK_POS_W-1:0] pos;
		logic [LEN_W-1:0]       run;
	} scan_res_t;

endpackage

### sv/bpfa_chunk_scan.sv
// Free-run tracker over one chunk of the page bitmap.
module bpfa_chunk_scan (
	input  logic [bpfa_pkg::CHUNK_BITS-1:0] bits,
	input  logic [bpfa_pkg::LEN_W-1:0]      run_in,
	input  logic [bpfa_pkg::LEN_W-1:0]      len,
	output bpfa_pkg::scan_res_t             res
);

	always_comb begin
		logic [bpfa_pkg::LEN_W-1:0]       run;
		logic                             hit;
		logic [bpfa_pkg::CHUNK_POS_W-1:0] pos;
		run = run_in;
		hit = 1'b0;
		pos = '0;
		for (int j = 0; j < bpfa_pkg::CHUNK_BITS; j++) begin
			if (bits[j]) begin
				run = '0;
			end else begin
				run = run + 1'b1;
			end
			if (!hit && run == len) begin
				hit = 1'b1;
				pos = bpfa_pkg::CHUNK_POS_W'(j);
			end
		end
		res.hit = hit;
		res.pos = pos;
		res.run = run;
	end

endmodule

### sv/bitmap_page_frame_allocator_core.sv
// Top level of the bitmap first-fit contiguous page allocator.
//
//   channel | direction | beat fields                    | handshake
//   --------+-----------+--------------------------------+---------------------
//   in      | into core | kind, first_page, run_length   | in_valid / in_ready
//   out     | from core | status, start_page             | out_valid / out_ready
//
// After reset the map RAM is swept to all-used, one word a cycle, with in_ready low.
// One request at a time. A zero length, an over-long allocate or a free that starts
// past the last page goes straight to the response. Allocate: read each 64-page word
// and search it 8 pages a cycle through the run tracker, then read and write back each
// word marked. Free: read and write back each word touched.
// The map RAM port is the limit; a held result stalls only the final response step.
module bitmap_page_frame_allocator_core #(
	parameter int NUM_PAGES = bpfa_pkg::NUM_PAGES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             kind,
	input  logic [bpfa_pkg::PAGE_W-1:0]      first_page,
	input  logic [bpfa_pkg::LEN_W-1:0]       run_length,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [bpfa_pkg::STATUS_W-1:0]    status,
	output logic [bpfa_pkg::PAGE_W-1:0]      start_page
);

	localparam int MAP_WORDS = (NUM_PAGES + bpfa_pkg::WORD_BITS - 1) / bpfa_pkg::WORD_BITS;
	localparam int WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int EW        = WAW + bpfa_pkg::WORD_IDX_W;
	localparam int XW        = ((EW > bpfa_pkg::LEN_W) ? EW : bpfa_pkg::LEN_W) + 1;
	localparam int WB        = bpfa_pkg::WORD_BITS;
	localparam int IW        = bpfa_pkg::WORD_IDX_W;

	logic [WB-1:0] mem [MAP_WORDS];
	logic [WB-1:0] rd_data_q;
	logic          mem_re;
	logic          mem_we;
	logic [WAW-1:0] mem_addr;
	logic [WB-1:0] mem_wdata;

	bpfa_pkg::state_t state_q, state_d;
	logic [WAW-1:0]                     word_q, word_d;
	logic [bpfa_pkg::CHUNK_IDX_W-1:0]   chunk_q, chunk_d;
	logic [bpfa_pkg::LEN_W-1:0]         run_q, run_d;
	logic [bpfa_pkg::LEN_W-1:0]         len_q, len_d;
	logic                               kind_q, kind_d;
	logic [XW-1:0]                      lo_q, lo_d;
	logic [XW-1:0]                      hi_q, hi_d;
	logic [bpfa_pkg::STATUS_W-1:0]      res_status_q, res_status_d;
	logic [bpfa_pkg::PAGE_W-1:0]        res_start_q, res_start_d;
	logic                               out_valid_q, out_valid_d;
	logic [bpfa_pkg::STATUS_W-1:0]      status_q, status_d;
	logic [bpfa_pkg::PAGE_W-1:0]        start_q, start_d;

	bpfa_pkg::scan_res_t                scan_res;
	logic [bpfa_pkg::CHUNK_BITS-1:0]    chunk_bits;
	logic [XW-1:0]                      end_page;
	logic [XW-1:0]                      run_start;
	logic [XW-1:0]                      free_hi;
	logic [WAW-1:0]                     lo_word;
	logic [WAW-1:0]                     hi_word;
	logic [IW-1:0]                      lo_bit;
	logic [IW-1:0]                      hi_bit;
	logic [WB-1:0]                      upd_mask;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_addr];
		end
	end

	assign chunk_bits = rd_data_q[chunk_q * bpfa_pkg::CHUNK_BITS +: bpfa_pkg::CHUNK_BITS];

	bpfa_chunk_scan u_scan (
		.bits   (chunk_bits),
		.run_in (run_q),
		.len    (len_q),
		.res    (scan_res)
	);

	assign end_page  = XW'({word_q, chunk_q, scan_res.pos});
	assign run_start = end_page + XW'(1) - XW'(len_q);
	assign free_hi   = XW'(first_page) + XW'(run_length) - XW'(1);
	assign lo_word   = lo_q[EW-1:IW];
	assign hi_word   = hi_q[EW-1:IW];
	assign lo_bit    = (word_q == lo_word) ? lo_q[IW-1:0] : '0;
	assign hi_bit    = (word_q == hi_word) ? hi_q[IW-1:0] : IW'(WB - 1);
	assign upd_mask  = ({WB{1'b1}} << lo_bit) & ({WB{1'b1}} >> (IW'(WB - 1) - hi_bit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bpfa_pkg::S_INIT;
			word_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			word_q      <= word_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		chunk_q      <= chunk_d;
		run_q        <= run_d;
		len_q        <= len_d;
		kind_q       <= kind_d;
		lo_q         <= lo_d;
		hi_q         <= hi_d;
		res_status_q <= res_status_d;
		res_start_q  <= res_start_d;
		status_q     <= status_d;
		start_q      <= start_d;
	end

	always_comb begin
		state_d      = state_q;
		word_d       = word_q;
		chunk_d      = chunk_q;
		run_d        = run_q;
		len_d        = len_q;
		kind_d       = kind_q;
		lo_d         = lo_q;
		hi_d         = hi_q;
		res_status_d = res_status_q;
		res_start_d  = res_start_q;
		out_valid_d  = out_valid_q && !out_ready;
		status_d     = status_q;
		start_d      = start_q;
		in_ready     = 1'b0;
		mem_re       = 1'b0;
		mem_we       = 1'b0;
		mem_addr     = word_q;
		mem_wdata    = kind_q ? (rd_data_q & ~upd_mask) : (rd_data_q | upd_mask);

		unique case (state_q)
			bpfa_pkg::S_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = {WB{1'b1}};
				if (word_q == WAW'(MAP_WORDS - 1)) begin
					word_d  = '0;
					state_d = bpfa_pkg::S_IDLE;
				end else begin
					word_d = word_q + 1'b1;
				end
			end
			bpfa_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					len_d        = run_length;
					kind_d       = kind;
					res_status_d = bpfa_pkg::ST_OK;
					res_start_d  = '0;
					word_d       = '0;
					chunk_d      = '0;
					run_d        = '0;
					lo_d         = XW'(first_page);
					hi_d         = (free_hi > XW'(NUM_PAGES - 1)) ? XW'(NUM_PAGES - 1) : free_hi;
					if (run_length == '0) begin
						res_status_d = bpfa_pkg::ST_ZERO;
						state_d      = bpfa_pkg::S_RESP;
					end else if (kind == bpfa_pkg::KIND_ALLOC) begin
						if (XW'(run_length) > XW'(NUM_PAGES)) begin
							res_status_d = bpfa_pkg::ST_NOSPACE;
							state_d      = bpfa_pkg::S_RESP;
						end else begin
							state_d = bpfa_pkg::S_SCAN_RD;
						end
					end else if (XW'(first_page) >= XW'(NUM_PAGES)) begin
						state_d = bpfa_pkg::S_RESP;
					end else begin
						word_d  = first_page[bpfa_pkg::PAGE_W-1:IW] > (bpfa_pkg::PAGE_W - IW)'(MAP_WORDS - 1)
							? '0 : WAW'(first_page[bpfa_pkg::PAGE_W-1:IW]);
						state_d = bpfa_pkg::S_UPD_RD;
					end
				end
			end
			bpfa_pkg::S_SCAN_RD: begin
				mem_re  = 1'b1;
				state_d = bpfa_pkg::S_SCAN;
			end
			bpfa_pkg::S_SCAN: begin
				run_d = scan_res.run;
				if (scan_res.hit) begin
					lo_d         = run_start;
					hi_d         = end_page;
					word_d       = run_start[EW-1:IW];
					res_start_d  = run_start[bpfa_pkg::PAGE_W-1:0];
					state_d      = bpfa_pkg::S_UPD_RD;
				end else if (chunk_q == bpfa_pkg::CHUNK_IDX_W'(bpfa_pkg::CHUNKS - 1)) begin
					chunk_d = '0;
					if (word_q == WAW'(MAP_WORDS - 1)) begin
						res_status_d = bpfa_pkg::ST_NOSPACE;
						state_d      = bpfa_pkg::S_RESP;
					end else begin
						mem_re   = 1'b1;
						mem_addr = word_q + 1'b1;
						word_d   = word_q + 1'b1;
					end
				end else begin
					chunk_d = chunk_q + 1'b1;
				end
			end
			bpfa_pkg::S_UPD_RD: begin
				mem_re  = 1'b1;
				state_d = bpfa_pkg::S_UPD_WR;
			end
			bpfa_pkg::S_UPD_WR: begin
				mem_we = 1'b1;
				if (word_q == hi_word) begin
					state_d = bpfa_pkg::S_RESP;
				end else begin
					word_d  = word_q + 1'b1;
					state_d = bpfa_pkg::S_UPD_RD;
				end
			end
			bpfa_pkg::S_RESP: begin
				if (!out_valid_q || out_ready) begin
					out_valid_d = 1'b1;
					status_d    = res_status_q;
					start_d     = (res_status_q == bpfa_pkg::ST_OK && kind_q == bpfa_pkg::KIND_ALLOC)
						? res_start_q : '0;
					state_d     = bpfa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bpfa_pkg::S_IDLE;
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign start_page = start_q;

endmodule
